FILE: rtl/assert_macros.svh
// Assertion macros shared by the coordinate parser modules.
// Each macro expects the signals clk and arst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define FCSV_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define FCSV_ASSERT_NEVER(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/fcsv_pkg.sv
// Shared types and constants for the framed CSV coordinate parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package fcsv_pkg;

	localparam logic [7:0] CH_START = 8'h24;
	localparam logic [7:0] CH_END   = 8'h23;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NUL   = 8'h00;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [16:0] MAG_LIMIT = 17'd32768;
	localparam logic [15:0] POS_MAX   = 16'd32767;

	localparam logic [1:0] LAST_FIELD = 2'd3;

	// Token kinds carried from the front end to the back end
	localparam logic [1:0] TOK_START = 2'd0;
	localparam logic [1:0] TOK_END   = 2'd1;
	localparam logic [1:0] TOK_TEXT  = 2'd2;

	// Field parse phases
	localparam logic [1:0] PH_SKIP   = 2'd0;
	localparam logic [1:0] PH_DIGITS = 2'd1;
	localparam logic [1:0] PH_DONE   = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic       digit;
		logic       space;
		logic       plus;
		logic       minus;
		logic       comma;
		logic [3:0] digit_val;
	} tok_t;

endpackage

`default_nettype wire

FILE: rtl/fcsv_front.sv
// Front end: accepts received bytes, tracks framing and text length, classifies kept bytes.
// Depends on fcsv_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module fcsv_front #(
	parameter int MAX_TEXT = 31
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic [7:0]    rx_byte,
	input  wire logic          q_full,
	output logic               push,
	output fcsv_pkg::tok_t     tok
);
	import fcsv_pkg::*;

	localparam int CW = $clog2(MAX_TEXT + 1);

	logic          in_frame_q;
	logic          text_ended_q;
	logic [CW-1:0] text_count_q;
	logic          accept;
	logic          is_start;
	logic          is_end;
	logic          room;
	logic          keep_text;

	assign in_stall  = q_full;
	assign accept    = in_valid && !q_full;
	assign is_start  = (rx_byte == CH_START);
	assign is_end    = (rx_byte == CH_END);
	assign room      = (text_count_q < CW'(MAX_TEXT));
	assign keep_text = in_frame_q && !is_end && room && !text_ended_q && (rx_byte != CH_NUL);

	assign push = accept && (is_start || (in_frame_q && is_end) || keep_text);

	always_comb begin
		tok.kind      = is_start ? TOK_START : (is_end ? TOK_END : TOK_TEXT);
		tok.digit     = rx_byte inside {[8'h30:8'h39]};
		tok.space     = (rx_byte == CH_SPACE) || (rx_byte inside {[8'd9:8'd13]});
		tok.plus      = (rx_byte == CH_PLUS);
		tok.minus     = (rx_byte == CH_MINUS);
		tok.comma     = (rx_byte == CH_COMMA);
		tok.digit_val = rx_byte[3:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q   <= 1'b0;
			text_ended_q <= 1'b0;
			text_count_q <= '0;
		end else if (accept) begin
			if (is_start) begin
				in_frame_q   <= 1'b1;
				text_ended_q <= 1'b0;
				text_count_q <= '0;
			end else if (in_frame_q) begin
				if (is_end) begin
					in_frame_q <= 1'b0;
				end else if (room) begin
					text_count_q <= text_count_q + CW'(1);
					// a zero byte ends the usable text of this frame
					if (rx_byte == CH_NUL)
						text_ended_q <= 1'b1;
				end
			end
		end
	end

	`FCSV_ASSERT_NEVER(a_count_bound, text_count_q > CW'(MAX_TEXT), "text count beyond limit")
	`FCSV_ASSERT(a_text_in_frame,
		(push && tok.kind == TOK_TEXT) |-> (in_frame_q && !text_ended_q),
		"text pushed outside usable frame")

endmodule

`default_nettype wire

FILE: rtl/fcsv_queue.sv
// Short token queue between the front end and the back end.
// Depends on fcsv_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module fcsv_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire fcsv_pkg::tok_t  push_tok,
	output logic                 full,
	input  wire logic            pop,
	output logic                 not_empty,
	output fcsv_pkg::tok_t       head_tok
);
	import fcsv_pkg::*;

	localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	tok_t            slot_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CNTW-1:0] count_q;

	assign full      = (count_q == CNTW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head_tok  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_tok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop)
				count_q <= count_q + CNTW'(1);
			else if (pop && !push)
				count_q <= count_q - CNTW'(1);
		end
	end

	`FCSV_ASSERT_NEVER(a_no_overflow, push && full, "push into full queue")
	`FCSV_ASSERT_NEVER(a_no_underflow, pop && !not_empty, "pop from empty queue")

endmodule

`default_nettype wire

FILE: rtl/fcsv_back.sv
// Back end: parses tokens into four saturated fields and issues one result per closed frame.
// Depends on fcsv_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module fcsv_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            tok_valid,
	input  wire fcsv_pkg::tok_t  tok,
	output logic                 tok_pop,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output logic signed [15:0]   object_x,
	output logic signed [15:0]   object_y,
	output logic signed [15:0]   beam_x,
	output logic signed [15:0]   beam_y,
	output logic                 frame_valid
);
	import fcsv_pkg::*;

	logic [1:0]  field_number_q;
	logic [1:0]  field_phase_q;
	logic        field_negative_q;
	logic [16:0] acc_q;
	logic [15:0] pending_q [3];
	logic [15:0] field_value_q [4];

	logic [15:0] out_q [4];
	logic        out_valid_q;
	logic        frame_valid_q;

	logic        out_free;
	logic        take_start;
	logic        take_end;
	logic        take_text;
	logic        sep;
	logic [1:0]  eff_phase;
	logic [19:0] acc_x10;
	logic [19:0] acc_sum;
	logic [16:0] acc_next;
	logic [15:0] finished;
	logic        complete;

	assign out_free   = !out_valid_q || !out_stall;
	assign tok_pop    = tok_valid && ((tok.kind != TOK_END) || out_free);
	assign take_start = tok_pop && (tok.kind == TOK_START);
	assign take_end   = tok_pop && (tok.kind == TOK_END);
	assign take_text  = tok_pop && (tok.kind == TOK_TEXT);
	assign sep        = tok.comma && (field_number_q != LAST_FIELD);
	assign complete   = (field_number_q == LAST_FIELD);

	// first non-space byte of a field decides whether digits follow
	assign eff_phase = (field_phase_q == PH_SKIP) ? (tok.digit ? PH_DIGITS : PH_DONE)
		: field_phase_q;

	assign acc_x10  = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0};
	assign acc_sum  = acc_x10 + {16'd0, tok.digit_val};
	assign acc_next = (acc_sum > {3'b000, MAG_LIMIT}) ? MAG_LIMIT : acc_sum[16:0];

	always_comb begin
		if (field_negative_q)
			finished = 16'd0 - acc_q[15:0] - {acc_q[16], 15'd0};
		else if (acc_q > {1'b0, POS_MAX})
			finished = POS_MAX;
		else
			finished = acc_q[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_number_q   <= '0;
			field_phase_q    <= PH_SKIP;
			field_negative_q <= 1'b0;
			acc_q            <= '0;
			for (int i = 0; i < 3; i++)
				pending_q[i] <= '0;
			for (int i = 0; i < 4; i++)
				field_value_q[i] <= '1;
		end else if (take_start) begin
			field_number_q   <= '0;
			field_phase_q    <= PH_SKIP;
			field_negative_q <= 1'b0;
			acc_q            <= '0;
		end else if (take_end) begin
			if (complete) begin
				for (int i = 0; i < 3; i++)
					field_value_q[i] <= pending_q[i];
				field_value_q[3] <= finished;
			end
		end else if (take_text) begin
			if (sep) begin
				pending_q[field_number_q] <= finished;
				field_number_q   <= field_number_q + 2'd1;
				field_phase_q    <= PH_SKIP;
				field_negative_q <= 1'b0;
				acc_q            <= '0;
			end else if (field_phase_q == PH_SKIP && tok.space) begin
				// hold: leading whitespace
			end else if (field_phase_q == PH_SKIP && (tok.plus || tok.minus)) begin
				field_negative_q <= tok.minus;
				field_phase_q    <= PH_DIGITS;
			end else if (eff_phase == PH_DIGITS && tok.digit) begin
				field_phase_q <= PH_DIGITS;
				acc_q         <= acc_next;
			end else begin
				field_phase_q <= PH_DONE;
			end
		end
	end

	// output register: load on a closing request, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take_end) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_end) begin
			frame_valid_q <= complete;
			for (int i = 0; i < 3; i++)
				out_q[i] <= complete ? pending_q[i] : field_value_q[i];
			out_q[3] <= complete ? finished : field_value_q[3];
		end
	end

	assign out_valid   = out_valid_q;
	assign frame_valid = frame_valid_q;
	assign object_x    = $signed(out_q[0]);
	assign object_y    = $signed(out_q[1]);
	assign beam_x      = $signed(out_q[2]);
	assign beam_y      = $signed(out_q[3]);

	`FCSV_ASSERT_NEVER(a_acc_bound, acc_q > MAG_LIMIT, "accumulator beyond saturation limit")
	`FCSV_ASSERT(a_hold_result, (out_valid_q && out_stall) |=> out_valid_q,
		"result lost while stalled")

endmodule

`default_nettype wire

FILE: rtl/framed_csv_coordinate_parser_core.sv
// Path: a closing '#' is written into the token queue, popped once the tokens queued ahead
// of it are taken and the result register is free, then loaded into the result register.
// Throughput: one byte per cycle; input stall rises only when the four-entry token
// queue is full, which happens while the result register is held by out_stall.
// Reset: arst_n clears framing, parse state and queue; stored coordinates reset to -1.
// Depends on fcsv_pkg, fcsv_front, fcsv_queue, fcsv_back.
`default_nettype none

module framed_csv_coordinate_parser_core #(
	parameter int MAX_TEXT = 31
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic [7:0]    rx_byte,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic signed [15:0] object_x,
	output logic signed [15:0] object_y,
	output logic signed [15:0] beam_x,
	output logic signed [15:0] beam_y,
	output logic               frame_valid
);
	import fcsv_pkg::*;

	tok_t push_tok;
	tok_t head_tok;
	logic push;
	logic q_full;
	logic q_not_empty;
	logic pop;

	fcsv_front #(
		.MAX_TEXT(MAX_TEXT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.q_full   (q_full),
		.push     (push),
		.tok      (push_tok)
	);

	fcsv_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_tok  (push_tok),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.head_tok  (head_tok)
	);

	fcsv_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.tok_valid   (q_not_empty),
		.tok         (head_tok),
		.tok_pop     (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.object_x    (object_x),
		.object_y    (object_y),
		.beam_x      (beam_x),
		.beam_y      (beam_y),
		.frame_valid (frame_valid)
	);

endmodule

`default_nettype wire
